// ===== sv/variable_partition_allocator_core_defines.svh =====
// Assertion macros for the partition allocator core.
// Used by the top level only; requires nothing else.
`ifndef VARIABLE_PARTITION_ALLOCATOR_CORE_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define VPA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VPA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define VPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/vpa_pkg.sv =====
// Shared types, codes and the placement compare for the partition allocator.
// No dependencies.
`default_nettype none
package vpa_pkg;
   typedef logic [15:0] addr_type;

   localparam int CSR_AW = 4;
   localparam logic [1:0] REG_POLICY   = 2'd0;
   localparam logic [1:0] REG_MEM_SIZE = 2'd1;
   localparam logic [1:0] REG_MIN_FRAG = 2'd2;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_NOFIT = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_NOID  = 3'd3;
   localparam logic [2:0] ST_ZERO  = 3'd4;

   localparam addr_type   RESET_MEM_SIZE = 16'd1024;
   localparam logic [7:0] RESET_MIN_FRAG = 8'd10;
   localparam addr_type   MEM_BASE       = 16'd0;

   typedef struct packed {
      addr_type start;
      addr_type len;
   } seg_type;

   typedef struct packed {
      addr_type id;
      addr_type start;
      addr_type len;
   } used_type;

   typedef struct packed {
      logic wr;
      logic set_vld;
      logic clr_vld;
   } tbl_cmd_type;

   function automatic logic seg_better(logic [1:0] pol, addr_type cs, addr_type cl,
                                       addr_type bs, addr_type bl, addr_type size);
      logic r;
      if (pol == POL_WORST) begin
         r = (cl != bl) ? (cl > bl) : (cs < bs);
      end else if (cl < size) begin
         r = 1'b0;
      end else if (bl < size) begin
         r = 1'b1;
      end else if (pol == POL_BEST && cl != bl) begin
         r = cl < bl;
      end else begin
         r = cs < bs;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== sv/vpa_if.sv =====
// Request and response channel interfaces of the partition allocator.
// Depends on vpa_pkg.
`default_nettype none
interface vpa_req_if;
   import vpa_pkg::*;
   logic     valid;
   logic     ready;
   logic     cmd;
   addr_type request_size;
   addr_type release_id;
   modport source (output valid, cmd, request_size, release_id, input ready);
   modport sink (input valid, cmd, request_size, release_id, output ready);
endinterface

interface vpa_rsp_if;
   import vpa_pkg::*;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   addr_type   granted_id;
   addr_type   block_start;
   addr_type   block_size;
   modport source (output valid, status, granted_id, block_start, block_size, input ready);
   modport sink (input valid, status, granted_id, block_start, block_size, output ready);
endinterface
`default_nettype wire

// ===== sv/vpa_regs.sv =====
// Configuration registers behind the APB-style port.
// Depends on vpa_pkg; flags a table reinit after a memory_size write.
`default_nettype none
module vpa_regs
   import vpa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready,
   output logic [1:0]            policy,
   output addr_type              memory_size,
   output logic [7:0]            min_fragment,
   output logic                  init_req
);
   logic [1:0] policy_ff, policy_in;
   addr_type   msize_ff, msize_in;
   logic [7:0] minf_ff, minf_in;
   logic       init_ff, init_in;
   logic       wr;
   logic [1:0] idx;

   assign pready = 1'b1;
   assign idx    = paddr[3:2];
   assign wr     = psel & penable & pwrite;

   always_comb begin
      policy_in = policy_ff;
      msize_in  = msize_ff;
      minf_in   = minf_ff;
      init_in   = 1'b0;
      if (wr) begin
         case (idx)
            REG_POLICY: policy_in = pwdata[1:0];
            REG_MEM_SIZE: begin
               msize_in = pwdata[15:0];
               init_in  = 1'b1;
            end
            REG_MIN_FRAG: minf_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_POLICY:   prdata = {30'd0, policy_ff};
         REG_MEM_SIZE: prdata = {16'd0, msize_ff};
         REG_MIN_FRAG: prdata = {24'd0, minf_ff};
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_FIRST;
         msize_ff  <= RESET_MEM_SIZE;
         minf_ff   <= RESET_MIN_FRAG;
         init_ff   <= 1'b0;
      end else begin
         policy_ff <= policy_in;
         msize_ff  <= msize_in;
         minf_ff   <= minf_in;
         init_ff   <= init_in;
      end
   end

   assign policy       = policy_ff;
   assign memory_size  = msize_ff;
   assign min_fragment = minf_ff;
   assign init_req     = init_ff;
endmodule
`default_nettype wire

// ===== sv/vpa_ftab.sv =====
// Free segment table: start/length memory with registered read, valid flops.
// Depends on vpa_pkg.
`default_nettype none
module vpa_ftab
   import vpa_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int IW = $clog2(DEPTH)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        init,
   input  wire addr_type    init_len,
   input  wire logic [IW-1:0] raddr,
   output seg_type          rdata,
   input  wire tbl_cmd_type cmd,
   input  wire logic [IW-1:0] waddr,
   input  wire seg_type     wdata,
   input  wire logic [IW-1:0] caddr,
   output logic [DEPTH-1:0] vld
);
   seg_type          mem_ff [DEPTH];
   seg_type          rd_ff;
   logic [DEPTH-1:0] vld_ff, vld_in;

   always_comb begin
      vld_in = vld_ff;
      if (init) begin
         vld_in = {{(DEPTH-1){1'b0}}, 1'b1};
      end else begin
         if (cmd.clr_vld) vld_in[caddr] = 1'b0;
         if (cmd.set_vld) vld_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= {{(DEPTH-1){1'b0}}, 1'b1};
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (init) begin
         mem_ff[0] <= '{start: MEM_BASE, len: init_len};
      end else if (cmd.wr) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;
   assign vld   = vld_ff;
endmodule
`default_nettype wire

// ===== sv/vpa_utab.sv =====
// Granted block table: id/start/length memory with registered read, valid flops.
// Depends on vpa_pkg.
`default_nettype none
module vpa_utab
   import vpa_pkg::*;
#(
   parameter int DEPTH = 15,
   localparam int IW = $clog2(DEPTH)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        init,
   input  wire logic [IW-1:0] raddr,
   output used_type         rdata,
   input  wire tbl_cmd_type cmd,
   input  wire logic [IW-1:0] waddr,
   input  wire used_type    wdata,
   input  wire logic [IW-1:0] caddr,
   output logic [DEPTH-1:0] vld
);
   used_type         mem_ff [DEPTH];
   used_type         rd_ff;
   logic [DEPTH-1:0] vld_ff, vld_in;

   always_comb begin
      vld_in = vld_ff;
      if (init) begin
         vld_in = '0;
      end else begin
         if (cmd.clr_vld) vld_in[caddr] = 1'b0;
         if (cmd.set_vld) vld_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;
   assign vld   = vld_ff;
endmodule
`default_nettype wire

// ===== sv/variable_partition_allocator_core.sv =====
// Top level of the partition allocator: request sequencer, tables, registers.
// Depends on vpa_pkg, vpa_if, vpa_regs, vpa_ftab, vpa_utab and the defines header.
//
//   port     | kind         | moves
//   req_ch   | valid/ready  | request: cmd, request_size, release_id
//   rsp_ch   | valid/ready  | response: status, granted_id, block_start, block_size
//   csr      | APB write/rd | policy, memory_size, min_fragment
//
// One request at a time; each pass scans a table one entry a cycle from its memory.
// Allocate: a free table scan, then the grant write, before the response register.
// Free: a block table scan, then a free table merge scan and the merge write.
// Zero size, or a full block table: straight to the response. A held response stalls the sequencer.
// After reset and after a memory_size write, the free table is rebuilt and the block table cleared.
`default_nettype none
`include "variable_partition_allocator_core_defines.svh"
module variable_partition_allocator_core
   import vpa_pkg::*;
#(
   parameter int MAX_BLOCKS = 15,
   parameter int MAX_FREE   = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   vpa_req_if.sink                req_ch,
   vpa_rsp_if.source              rsp_ch,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   localparam int FIW = $clog2(MAX_FREE);
   localparam int BIW = $clog2(MAX_BLOCKS);
   localparam int SCW = (FIW > BIW) ? FIW : BIW;
   localparam logic [SCW-1:0] FREE_LAST = SCW'(MAX_FREE - 1);
   localparam logic [SCW-1:0] BLK_LAST  = SCW'(MAX_BLOCKS - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FSCAN  = 3'd1;
   localparam logic [2:0] S_AWRITE = 3'd2;
   localparam logic [2:0] S_USCAN  = 3'd3;
   localparam logic [2:0] S_UCHK   = 3'd4;
   localparam logic [2:0] S_MSCAN  = 3'd5;
   localparam logic [2:0] S_MWRITE = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [1:0] policy;
   addr_type   memory_size;
   logic [7:0] min_fragment;
   logic       cfg_init;

   vpa_regs u_regs (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .policy, .memory_size, .min_fragment, .init_req(cfg_init)
   );

   logic init_pend_ff, init_pend_in;
   logic tbl_init;
   assign tbl_init = init_pend_ff | cfg_init;

   logic [SCW-1:0]      cnt_ff, cnt_in;
   seg_type             frd;
   tbl_cmd_type         fcmd;
   logic [FIW-1:0]      fwaddr, fcaddr;
   seg_type             fwdata;
   logic [MAX_FREE-1:0] fvld;

   vpa_ftab #(.DEPTH(MAX_FREE)) u_ftab (
      .clock, .reset, .init(tbl_init), .init_len(memory_size),
      .raddr(cnt_ff[FIW-1:0]), .rdata(frd), .cmd(fcmd), .waddr(fwaddr),
      .wdata(fwdata), .caddr(fcaddr), .vld(fvld)
   );

   used_type              urd;
   tbl_cmd_type           ucmd;
   logic [BIW-1:0]        uwaddr, ucaddr;
   used_type              uwdata;
   logic [MAX_BLOCKS-1:0] uvld;

   vpa_utab #(.DEPTH(MAX_BLOCKS)) u_utab (
      .clock, .reset, .init(tbl_init), .raddr(cnt_ff[BIW-1:0]), .rdata(urd),
      .cmd(ucmd), .waddr(uwaddr), .wdata(uwdata), .caddr(ucaddr), .vld(uvld)
   );

   logic [2:0]     st_ff, st_in;
   logic           iss_ff, iss_in;
   logic           proc_ff, proc_in;
   logic [SCW-1:0] pidx_ff, pidx_in;
   logic           plast_ff, plast_in;
   addr_type       size_ff, size_in;
   addr_type       rid_ff, rid_in;
   addr_type       idc_ff, idc_in;
   logic [BIW-1:0] uslot_ff, uslot_in;
   logic           pk_ff, pk_in;
   logic [FIW-1:0] pk_idx_ff, pk_idx_in;
   addr_type       pk_start_ff, pk_start_in;
   addr_type       pk_len_ff, pk_len_in;
   logic           fnd_ff, fnd_in;
   logic [BIW-1:0] u_idx_ff, u_idx_in;
   addr_type       u_start_ff, u_start_in;
   addr_type       u_len_ff, u_len_in;
   logic           lf_ff, lf_in;
   logic [FIW-1:0] l_idx_ff, l_idx_in;
   addr_type       l_start_ff, l_start_in;
   addr_type       l_len_ff, l_len_in;
   logic           rf_ff, rf_in;
   logic [FIW-1:0] r_idx_ff, r_idx_in;
   addr_type       r_len_ff, r_len_in;
   logic           sf_ff, sf_in;
   logic [FIW-1:0] s_idx_ff, s_idx_in;
   logic [2:0]     res_st_ff, res_st_in;
   addr_type       res_id_ff, res_id_in;
   addr_type       res_start_ff, res_start_in;
   addr_type       res_size_ff, res_size_in;
   logic           rv_ff, rv_in;
   logic [2:0]     rs_st_ff, rs_st_in;
   addr_type       rs_id_ff, rs_id_in;
   addr_type       rs_start_ff, rs_start_in;
   addr_type       rs_size_ff, rs_size_in;

   logic           req_fire;
   logic           uslot_any;
   logic [BIW-1:0] uslot;
   logic [SCW-1:0] last;
   logic           f_ent_vld, u_ent_vld;
   addr_type       u_end, rem, f_end;
   logic           load;

   assign req_ch.ready = (st_ff == S_IDLE) && !tbl_init;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign last         = (st_ff == S_USCAN) ? BLK_LAST : FREE_LAST;
   assign f_ent_vld    = proc_ff && fvld[pidx_ff[FIW-1:0]];
   assign u_ent_vld    = proc_ff && uvld[pidx_ff[BIW-1:0]];
   assign u_end        = u_start_ff + u_len_ff;
   assign f_end        = frd.start + frd.len;
   assign rem          = pk_len_ff - size_ff;
   assign load         = (st_ff == S_DONE) && (!rv_ff || rsp_ch.ready);

   always_comb begin
      uslot_any = 1'b0;
      uslot     = '0;
      for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
         if (!uvld[i]) begin
            uslot_any = 1'b1;
            uslot     = BIW'(i);
         end
      end
   end

   always_comb begin
      st_in = st_ff;
      iss_in = iss_ff;
      cnt_in = cnt_ff;
      proc_in = iss_ff;
      pidx_in = cnt_ff;
      plast_in = (cnt_ff == last);
      size_in = size_ff;
      rid_in = rid_ff;
      idc_in = idc_ff;
      uslot_in = uslot_ff;
      pk_in = pk_ff;
      pk_idx_in = pk_idx_ff;
      pk_start_in = pk_start_ff;
      pk_len_in = pk_len_ff;
      fnd_in = fnd_ff;
      u_idx_in = u_idx_ff;
      u_start_in = u_start_ff;
      u_len_in = u_len_ff;
      lf_in = lf_ff;
      l_idx_in = l_idx_ff;
      l_start_in = l_start_ff;
      l_len_in = l_len_ff;
      rf_in = rf_ff;
      r_idx_in = r_idx_ff;
      r_len_in = r_len_ff;
      sf_in = sf_ff;
      s_idx_in = s_idx_ff;
      res_st_in = res_st_ff;
      res_id_in = res_id_ff;
      res_start_in = res_start_ff;
      res_size_in = res_size_ff;
      init_pend_in = 1'b0;
      fcmd = '0;
      fwaddr = '0;
      fcaddr = '0;
      fwdata = '0;
      ucmd = '0;
      uwaddr = uslot_ff;
      ucaddr = u_idx_ff;
      uwdata = '{id: idc_ff, start: pk_start_ff, len: pk_len_ff};

      if (iss_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == last) iss_in = 1'b0;
      end

      case (st_ff)
         S_IDLE: begin
            if (req_fire) begin
               size_in      = req_ch.request_size;
               rid_in       = req_ch.release_id;
               res_id_in    = '0;
               res_start_in = '0;
               res_size_in  = '0;
               if (req_ch.cmd == CMD_FREE) begin
                  fnd_in = 1'b0;
                  iss_in = 1'b1;
                  cnt_in = '0;
                  st_in  = S_USCAN;
               end else if (req_ch.request_size == '0) begin
                  res_st_in = ST_ZERO;
                  st_in     = S_DONE;
               end else begin
                  idc_in = idc_ff + 1'b1;
                  if (!uslot_any) begin
                     res_st_in = ST_FULL;
                     st_in     = S_DONE;
                  end else begin
                     uslot_in = uslot;
                     pk_in    = 1'b0;
                     iss_in   = 1'b1;
                     cnt_in   = '0;
                     st_in    = S_FSCAN;
                  end
               end
            end
         end
         S_FSCAN: begin
            if (f_ent_vld && (!pk_ff ||
                seg_better(policy, frd.start, frd.len, pk_start_ff, pk_len_ff, size_ff))) begin
               pk_in       = 1'b1;
               pk_idx_in   = pidx_ff[FIW-1:0];
               pk_start_in = frd.start;
               pk_len_in   = frd.len;
            end
            if (proc_ff && plast_ff) st_in = S_AWRITE;
         end
         S_AWRITE: begin
            st_in = S_DONE;
            if (!pk_ff || pk_len_ff < size_ff) begin
               res_st_in = ST_NOFIT;
            end else begin
               res_st_in    = ST_OK;
               res_id_in    = idc_ff;
               res_start_in = pk_start_ff;
               ucmd.wr      = 1'b1;
               ucmd.set_vld = 1'b1;
               fwaddr       = pk_idx_ff;
               fcaddr       = pk_idx_ff;
               if (rem > {8'd0, min_fragment}) begin
                  res_size_in = size_ff;
                  uwdata.len  = size_ff;
                  fcmd.wr     = 1'b1;
                  fwdata      = '{start: pk_start_ff + size_ff, len: rem};
               end else begin
                  res_size_in  = pk_len_ff;
                  fcmd.clr_vld = 1'b1;
               end
            end
         end
         S_USCAN: begin
            if (u_ent_vld && !fnd_ff && urd.id == rid_ff) begin
               fnd_in     = 1'b1;
               u_idx_in   = pidx_ff[BIW-1:0];
               u_start_in = urd.start;
               u_len_in   = urd.len;
            end
            if (proc_ff && plast_ff) st_in = S_UCHK;
         end
         S_UCHK: begin
            if (!fnd_ff) begin
               res_st_in = ST_NOID;
               st_in     = S_DONE;
            end else begin
               ucmd.clr_vld = 1'b1;
               res_st_in    = ST_OK;
               res_id_in    = rid_ff;
               res_start_in = u_start_ff;
               res_size_in  = u_len_ff;
               lf_in        = 1'b0;
               rf_in        = 1'b0;
               sf_in        = 1'b0;
               iss_in       = 1'b1;
               cnt_in       = '0;
               st_in        = S_MSCAN;
            end
         end
         S_MSCAN: begin
            if (proc_ff && !fvld[pidx_ff[FIW-1:0]]) begin
               if (!sf_ff) begin
                  sf_in    = 1'b1;
                  s_idx_in = pidx_ff[FIW-1:0];
               end
            end else if (f_ent_vld) begin
               if (!lf_ff && f_end == u_start_ff) begin
                  lf_in      = 1'b1;
                  l_idx_in   = pidx_ff[FIW-1:0];
                  l_start_in = frd.start;
                  l_len_in   = frd.len;
               end else if (!rf_ff && frd.start == u_end) begin
                  rf_in    = 1'b1;
                  r_idx_in = pidx_ff[FIW-1:0];
                  r_len_in = frd.len;
               end
            end
            if (proc_ff && plast_ff) st_in = S_MWRITE;
         end
         S_MWRITE: begin
            st_in = S_DONE;
            if (lf_ff) begin
               fcmd.wr = 1'b1;
               fwaddr  = l_idx_ff;
               fcaddr  = r_idx_ff;
               fcmd.clr_vld = rf_ff;
               fwdata = '{start: l_start_ff,
                          len: l_len_ff + u_len_ff + (rf_ff ? r_len_ff : 16'd0)};
            end else if (rf_ff) begin
               fcmd.wr = 1'b1;
               fwaddr  = r_idx_ff;
               fwdata  = '{start: u_start_ff, len: r_len_ff + u_len_ff};
            end else if (sf_ff) begin
               fcmd.wr      = 1'b1;
               fcmd.set_vld = 1'b1;
               fwaddr       = s_idx_ff;
               fwdata       = '{start: u_start_ff, len: u_len_ff};
            end
         end
         S_DONE: begin
            if (load) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_comb begin
      rv_in       = load | (rv_ff & ~rsp_ch.ready);
      rs_st_in    = load ? res_st_ff : rs_st_ff;
      rs_id_in    = load ? res_id_ff : rs_id_ff;
      rs_start_in = load ? res_start_ff : rs_start_ff;
      rs_size_in  = load ? res_size_ff : rs_size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         iss_ff       <= 1'b0;
         proc_ff      <= 1'b0;
         idc_ff       <= '0;
         rv_ff        <= 1'b0;
         init_pend_ff <= 1'b1;
      end else begin
         st_ff        <= st_in;
         iss_ff       <= iss_in;
         proc_ff      <= proc_in;
         idc_ff       <= idc_in;
         rv_ff        <= rv_in;
         init_pend_ff <= init_pend_in;
      end
      cnt_ff       <= cnt_in;
      pidx_ff      <= pidx_in;
      plast_ff     <= plast_in;
      size_ff      <= size_in;
      rid_ff       <= rid_in;
      uslot_ff     <= uslot_in;
      pk_ff        <= pk_in;
      pk_idx_ff    <= pk_idx_in;
      pk_start_ff  <= pk_start_in;
      pk_len_ff    <= pk_len_in;
      fnd_ff       <= fnd_in;
      u_idx_ff     <= u_idx_in;
      u_start_ff   <= u_start_in;
      u_len_ff     <= u_len_in;
      lf_ff        <= lf_in;
      l_idx_ff     <= l_idx_in;
      l_start_ff   <= l_start_in;
      l_len_ff     <= l_len_in;
      rf_ff        <= rf_in;
      r_idx_ff     <= r_idx_in;
      r_len_ff     <= r_len_in;
      sf_ff        <= sf_in;
      s_idx_ff     <= s_idx_in;
      res_st_ff    <= res_st_in;
      res_id_ff    <= res_id_in;
      res_start_ff <= res_start_in;
      res_size_ff  <= res_size_in;
      rs_st_ff     <= rs_st_in;
      rs_id_ff     <= rs_id_in;
      rs_start_ff  <= rs_start_in;
      rs_size_ff   <= rs_size_in;
   end

   assign rsp_ch.valid       = rv_ff;
   assign rsp_ch.status      = rs_st_ff;
   assign rsp_ch.granted_id  = rs_id_ff;
   assign rsp_ch.block_start = rs_start_ff;
   assign rsp_ch.block_size  = rs_size_ff;

   `VPA_ASSERT_IMPLIES(a_proc_in_scan, clock, reset, proc_ff, (st_ff == S_FSCAN || st_ff == S_USCAN || st_ff == S_MSCAN), "scan data outside a scan state")
   `VPA_ASSERT_IMPLIES(a_merge_after_hit, clock, reset, st_ff == S_MSCAN, fnd_ff && !uvld[u_idx_ff], "merge scan without a released block")
   `VPA_ASSERT_IMPLIES(a_done_quiet, clock, reset, st_ff == S_DONE, !iss_ff && !proc_ff, "table scan still running at response")
   `VPA_ASSERT_NEXT(a_grant_marks_block, clock, reset, st_ff == S_AWRITE && ucmd.wr, uvld[uslot_ff], "granted block not marked valid")
endmodule
`default_nettype wire

// ===== verif/tb_vpa_scoreboard.sv =====
// Allocator state tracker that predicts each response and checks it.
// Depends on vpa_pkg.
`timescale 1ns / 100ps
package tb_vpa_sb_pkg;
   import vpa_pkg::*;

   typedef struct packed {
      logic [2:0] status;
      addr_type   id;
      addr_type   start;
      addr_type   size;
   } alloc_rsp_type;

   class alloc_tracker;
      localparam int NBLK = 15;
      localparam int NFREE = 16;
      logic [1:0] pol;
      addr_type   msize_cfg;
      logic [7:0] min_frag;
      addr_type   next_id;
      addr_type   fs [NFREE];
      addr_type   fl [NFREE];
      bit         fv [NFREE];
      addr_type   uid [NBLK];
      addr_type   us [NBLK];
      addr_type   ul [NBLK];
      bit         uv [NBLK];
      alloc_rsp_type pending[$];
      int         errors;
      int         checked;
      int         ok_count;

      function new();
         pol = POL_FIRST;
         msize_cfg = RESET_MEM_SIZE;
         min_frag = RESET_MIN_FRAG;
         next_id = 0;
         errors = 0;
         checked = 0;
         ok_count = 0;
         rebuild();
      endfunction

      function void rebuild();
         for (int i = 0; i < NFREE; i++) begin
            fs[i] = 0; fl[i] = 0; fv[i] = 0;
         end
         for (int i = 0; i < NBLK; i++) begin
            uid[i] = 0; us[i] = 0; ul[i] = 0; uv[i] = 0;
         end
         fl[0] = msize_cfg;
         fv[0] = 1;
      endfunction

      function void write_reg(int idx, logic [31:0] val);
         if (idx == REG_POLICY) pol = val[1:0];
         else if (idx == REG_MEM_SIZE) begin
            msize_cfg = val[15:0];
            rebuild();
         end else if (idx == REG_MIN_FRAG) min_frag = val[7:0];
      endfunction

      function bit wins(int c, int b, addr_type size);
         if (pol == POL_WORST)
            return (fl[c] != fl[b]) ? (fl[c] > fl[b]) : (fs[c] < fs[b]);
         if (fl[c] < size) return 0;
         if (fl[b] < size) return 1;
         if (pol == POL_BEST && fl[c] != fl[b]) return fl[c] < fl[b];
         return fs[c] < fs[b];
      endfunction

      function void give_back(addr_type start, addr_type len);
         int lft, rgt, slot;
         addr_type fin;
         lft = -1; rgt = -1; slot = -1;
         fin = start + len;
         for (int i = 0; i < NFREE; i++) begin
            if (!fv[i]) begin
               if (slot < 0) slot = i;
            end else if (lft < 0 && addr_type'(fs[i] + fl[i]) == start) lft = i;
            else if (rgt < 0 && fs[i] == fin) rgt = i;
         end
         if (lft >= 0) begin
            fl[lft] = fl[lft] + len;
            if (rgt >= 0) begin
               fl[lft] = fl[lft] + fl[rgt];
               fv[rgt] = 0;
            end
         end else if (rgt >= 0) begin
            fs[rgt] = start;
            fl[rgt] = fl[rgt] + len;
         end else if (slot >= 0) begin
            fs[slot] = start; fl[slot] = len; fv[slot] = 1;
         end
      endfunction

      function void note_request(logic cmd, addr_type size, addr_type rid);
         alloc_rsp_type r;
         int pick, slot;
         r = '0; pick = -1; slot = -1;
         if (cmd == CMD_FREE) begin
            for (int i = 0; i < NBLK; i++)
               if (pick < 0 && uv[i] && uid[i] == rid) pick = i;
            if (pick < 0) r.status = ST_NOID;
            else begin
               uv[pick] = 0;
               r.id = uid[pick]; r.start = us[pick]; r.size = ul[pick];
               give_back(us[pick], ul[pick]);
            end
         end else if (size == 0) r.status = ST_ZERO;
         else begin
            next_id = next_id + 1;
            for (int i = 0; i < NBLK; i++)
               if (slot < 0 && !uv[i]) slot = i;
            if (slot < 0) r.status = ST_FULL;
            else begin
               for (int i = 0; i < NFREE; i++)
                  if (fv[i] && (pick < 0 || wins(i, pick, size))) pick = i;
               if (pick < 0 || fl[pick] < size) r.status = ST_NOFIT;
               else begin
                  uv[slot] = 1; uid[slot] = next_id; us[slot] = fs[pick];
                  if (fl[pick] - size > min_frag) begin
                     ul[slot] = size;
                     fs[pick] = fs[pick] + size;
                     fl[pick] = fl[pick] - size;
                  end else begin
                     ul[slot] = fl[pick];
                     fv[pick] = 0;
                  end
                  r.status = ST_OK; r.id = next_id; r.start = us[slot]; r.size = ul[slot];
               end
            end
         end
         pending.push_back(r);
      endfunction

      task check_response(alloc_rsp_type got);
         alloc_rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            report("unexpected response", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.status == ST_OK) ok_count++;
         if (got.status != want.status) report("status", got.status, want.status);
         if (got.id != want.id) report("granted_id", got.id, want.id);
         if (got.start != want.start) report("block_start", got.start, want.start);
         if (got.size != want.size) report("block_size", got.size, want.size);
      endtask

      task report(string what, int got, int want);
         errors++;
         $display("mismatch %s: got %0d expected %0d (response %0d)",
                  what, got, want, checked);
      endtask

      // Valid live id, or a random one when nothing is allocated.
      function addr_type live_id();
         int idx[$];
         for (int i = 0; i < NBLK; i++) if (uv[i]) idx.push_back(i);
         if (idx.size() == 0) return addr_type'($urandom);
         return uid[idx[$urandom_range(idx.size() - 1)]];
      endfunction
   endclass
endpackage

// ===== verif/tb_top.sv =====
// Top of the allocator testbench: clock, reset, drivers and phases.
// Depends on vpa_pkg, vpa_if, tb_vpa_sb_pkg and the allocator core.
`timescale 1ns / 100ps
module tb_top;
   import vpa_pkg::*;
   import tb_vpa_sb_pkg::*;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;
   int sent;
   int hold_cycles;
   bit drain_on;
   alloc_tracker trk;

   vpa_req_if req_ch ();
   vpa_rsp_if rsp_ch ();

   variable_partition_allocator_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= CSR_AW'(idx) << 2; pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      trk.write_reg(idx, val);
      psel <= 0; penable <= 0; pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic send(logic cmd, addr_type size, addr_type rid);
      int gap;
      gap = $urandom_range(4);
      if (sent % 200 > 150) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1; req_ch.cmd <= cmd;
      req_ch.request_size <= size; req_ch.release_id <= rid;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      trk.note_request(cmd, size, rid);
      sent++;
   endtask

   task automatic settle();
      req_ch.valid <= 0;
      while (trk.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      logic cmd;
      addr_type size;
      for (int k = 0; k < n; k++) begin
         cmd = $urandom_range(99) < 45;
         case ($urandom_range(9))
            0: size = addr_type'($urandom);
            1: size = '0;
            2, 3: size = addr_type'($urandom_range(300));
            default: size = addr_type'($urandom_range(1, 120));
         endcase
         if (cmd && $urandom_range(9) == 0) send(cmd, size, addr_type'($urandom));
         else send(cmd, size, cmd ? trk.live_id() : addr_type'($urandom));
      end
   endtask

   // Response side: random stall per response, with one long hold-off.
   initial begin
      alloc_rsp_type r;
      int stall;
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         stall = 0;
         if (rsp_ch.ready && rsp_ch.valid) begin
            r = '{rsp_ch.status, rsp_ch.granted_id, rsp_ch.block_start, rsp_ch.block_size};
            trk.check_response(r);
            stall = drain_on ? 0 : $urandom_range(4);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 0;
         end else if (stall > 0) begin
            rsp_ch.ready <= 0;
            hold_cycles = stall - 1;
         end else rsp_ch.ready <= 1;
      end
   end

   initial begin
      trk = new();
      sent = 0; hold_cycles = 0; drain_on = 0;
      reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      req_ch.valid = 0; req_ch.cmd = CMD_ALLOC;
      req_ch.request_size = '0; req_ch.release_id = '0;
      repeat (2) @(posedge clock);
      reset <= 0;
      repeat (3) @(posedge clock);

      // directed: extremes, every status, the reset policy and policy code 3
      send(CMD_ALLOC, 0, 0);
      send(CMD_ALLOC, 16'hFFFF, 16'hFFFF);
      send(CMD_ALLOC, 100, 0);
      send(CMD_ALLOC, 1015, 0);
      send(CMD_FREE, 0, 16'hFFFF);
      send(CMD_FREE, 0, 1);
      send(CMD_FREE, 0, 1);
      send(CMD_FREE, 16'hFFFF, 4);
      for (int i = 0; i < 16; i++) send(CMD_ALLOC, 20, 0);
      settle();
      csr_write(REG_MEM_SIZE, 0);
      csr_write(REG_POLICY, 3);
      send(CMD_ALLOC, 1, 0);
      settle();
      csr_write(REG_MEM_SIZE, 16'hFFFF);
      csr_write(REG_MIN_FRAG, 255);
      send(CMD_ALLOC, 16'hFF00, 0);

      hold_cycles = 400;
      random_phase(100);
      for (int p = 0; p < 12; p++) begin
         settle();
         csr_write(REG_POLICY, p % 4);
         csr_write(REG_MIN_FRAG, (p % 3 == 0) ? 0 : (p % 3 == 1) ? 255 : $urandom_range(255));
         csr_write(REG_MEM_SIZE, (p == 5) ? 1 : (p == 7) ? 16'hFFFF : $urandom_range(200, 2000));
         random_phase(110);
      end
      drain_on = 1;
      settle();

      $display("covered %0d requests, %0d responses (%0d granted or freed)",
               sent, trk.checked, trk.ok_count);
      $display("policies 0..3, memory sizes 0..65535, fragment limits 0..255");
      if (trk.errors == 0 && trk.pending.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/vpa_pkg.sv
sv/vpa_if.sv
sv/vpa_regs.sv
sv/vpa_ftab.sv
sv/vpa_utab.sv
sv/variable_partition_allocator_core.sv
verif/tb_vpa_scoreboard.sv
verif/tb_top.sv
